// ----- rtl/lsrt_pkg.sv -----
package lsrt_pkg;

  localparam int FIELD_W    = 24;
  localparam int ANGLE_W    = 17;
  localparam int CMD_W      = 2;
  localparam int STEP_W     = 5;
  localparam int ATAN_W     = 28;
  localparam int X_W        = 33;
  localparam int Z_W        = 32;
  localparam int CS_W       = 30;
  localparam int A_W        = 18;
  localparam int FRAC_SHIFT = 28;
  localparam int ANG_SHIFT  = 15;

  localparam logic signed [X_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [A_W-1:0] DEG360 = 18'sd46080;
  localparam logic signed [A_W-1:0] DEG180 = 18'sd23040;
  localparam logic signed [A_W-1:0] DEG90  = 18'sd11520;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SHIFT  = 2'd1,
    CMD_ROTATE = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ANGLE,
    S_CORDIC,
    S_ROUND,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_WRITE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [FIELD_W-1:0] start_x;
    logic signed [FIELD_W-1:0] start_y;
    logic signed [FIELD_W-1:0] end_x;
    logic signed [FIELD_W-1:0] end_y;
    logic signed [FIELD_W-1:0] shift_x;
    logic signed [FIELD_W-1:0] shift_y;
    logic signed [FIELD_W-1:0] center_x;
    logic signed [FIELD_W-1:0] center_y;
    logic signed [ANGLE_W-1:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] start_x;
    logic signed [FIELD_W-1:0] start_y;
    logic signed [FIELD_W-1:0] end_x;
    logic signed [FIELD_W-1:0] end_y;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic              capture;
    logic              apply;
    logic              angle_init;
    logic              cordic_step;
    logic              round;
    logic              diff;
    logic              mul;
    logic              acc;
    logic              write;
    logic              emit;
    logic [STEP_W-1:0] step;
    logic [1:0]        term;
    logic              endpt;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_rotate;
    logic out_busy;
  } ctl_sts_t;

  function automatic logic [ATAN_W-1:0] atan_q22(input logic [STEP_W-1:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      5'd0:    v = 28'd188743680;
      5'd1:    v = 28'd111421900;
      5'd2:    v = 28'd58872272;
      5'd3:    v = 28'd29884485;
      5'd4:    v = 28'd15000234;
      5'd5:    v = 28'd7507429;
      5'd6:    v = 28'd3754631;
      5'd7:    v = 28'd1877430;
      5'd8:    v = 28'd938729;
      5'd9:    v = 28'd469366;
      5'd10:   v = 28'd234683;
      5'd11:   v = 28'd117342;
      5'd12:   v = 28'd58671;
      5'd13:   v = 28'd29335;
      5'd14:   v = 28'd14668;
      5'd15:   v = 28'd7334;
      5'd16:   v = 28'd3667;
      5'd17:   v = 28'd1833;
      5'd18:   v = 28'd917;
      5'd19:   v = 28'd458;
      5'd20:   v = 28'd229;
      5'd21:   v = 28'd115;
      5'd22:   v = 28'd57;
      5'd23:   v = 28'd29;
      5'd24:   v = 28'd14;
      5'd25:   v = 28'd7;
      5'd26:   v = 28'd4;
      5'd27:   v = 28'd2;
      5'd28:   v = 28'd1;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/lsrt_in_if.sv -----
interface lsrt_in_if;
  import lsrt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [FIELD_W-1:0] start_x;
  logic signed [FIELD_W-1:0] start_y;
  logic signed [FIELD_W-1:0] end_x;
  logic signed [FIELD_W-1:0] end_y;
  logic signed [FIELD_W-1:0] shift_x;
  logic signed [FIELD_W-1:0] shift_y;
  logic signed [FIELD_W-1:0] center_x;
  logic signed [FIELD_W-1:0] center_y;
  logic signed [ANGLE_W-1:0] angle;

  modport source (
    output valid, cmd, start_x, start_y, end_x, end_y,
    output shift_x, shift_y, center_x, center_y, angle,
    input  ready
  );

  modport sink (
    input  valid, cmd, start_x, start_y, end_x, end_y,
    input  shift_x, shift_y, center_x, center_y, angle,
    output ready
  );
endinterface

// ----- rtl/lsrt_out_if.sv -----
interface lsrt_out_if;
  import lsrt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] out_start_x;
  logic signed [FIELD_W-1:0] out_start_y;
  logic signed [FIELD_W-1:0] out_end_x;
  logic signed [FIELD_W-1:0] out_end_y;
  logic                      saturated;

  modport source (
    output valid, out_start_x, out_start_y, out_end_x, out_end_y, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_start_x, out_start_y, out_end_x, out_end_y, saturated,
    output ready
  );
endinterface

// ----- rtl/line_segment_rotate_translate.sv -----
// Line segment holder: keeps two endpoints in signed Q15.8 and applies one
// request at a time.
// Input channel in_ch (valid/ready): cmd selects load endpoints, translate by
// shift_x/shift_y, or rotate about center_x/center_y by angle in 1/128 degree.
// Result channel out_ch (valid/ready): one result per request carrying the
// current endpoints and a saturated flag for any clamped coordinate.
// Load, translate and unknown commands go through S_DECODE and S_EMIT; rotate
// also runs S_ANGLE, one CORDIC step per cycle for sin/cos, S_ROUND, then eight
// products through one shared multiplier with a multiply and an accumulate
// state each, before S_EMIT. A new request is taken in the cycle after the
// result is loaded; the block takes no request while one is in progress.
// The result sits in an output register: a new request is accepted while it
// waits; if the receiver still stalls when the next result is ready, the block
// holds that result internally and takes no further request until it drains.
// Reset clears the endpoints to zero and drops any pending result.
module line_segment_rotate_translate #(
  parameter int COORD_WIDTH  = 24,
  parameter int CORDIC_STEPS = 16
) (
  input logic  clk,
  input logic  rst_n,
  lsrt_in_if.sink    in_ch,
  lsrt_out_if.source out_ch
);
  import lsrt_pkg::*;

  in_item_t  in_item;
  out_item_t out_item;
  ctl_cmd_t  ctl;
  ctl_sts_t  sts;
  logic      in_ready;
  logic      out_valid;

  assign in_item.cmd      = in_ch.cmd;
  assign in_item.start_x  = in_ch.start_x;
  assign in_item.start_y  = in_ch.start_y;
  assign in_item.end_x    = in_ch.end_x;
  assign in_item.end_y    = in_ch.end_y;
  assign in_item.shift_x  = in_ch.shift_x;
  assign in_item.shift_y  = in_ch.shift_y;
  assign in_item.center_x = in_ch.center_x;
  assign in_item.center_y = in_ch.center_y;
  assign in_item.angle    = in_ch.angle;

  lsrt_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .sts     (sts),
    .ctl     (ctl)
  );

  lsrt_dp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .ctl      (ctl),
    .sts      (sts),
    .out_item (out_item),
    .out_valid(out_valid),
    .out_ready(out_ch.ready)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.out_start_x = out_item.start_x;
  assign out_ch.out_start_y = out_item.start_y;
  assign out_ch.out_end_x   = out_item.end_x;
  assign out_ch.out_end_y   = out_item.end_y;
  assign out_ch.saturated   = out_item.saturated;

endmodule

// ----- rtl/lsrt_ctrl.sv -----
module lsrt_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsrt_pkg::ctl_sts_t sts,
  output lsrt_pkg::ctl_cmd_t ctl
);
  import lsrt_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        term_r, term_nxt;
  logic              endpt_r, endpt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      term_r  <= '0;
      endpt_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      term_r  <= term_nxt;
      endpt_r <= endpt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    term_nxt  = term_r;
    endpt_nxt = endpt_r;
    ctl       = '0;
    ctl.step  = step_r;
    ctl.term  = term_r;
    ctl.endpt = endpt_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_rotate) begin
          state_nxt = S_ANGLE;
        end else begin
          ctl.apply = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_ANGLE: begin
        ctl.angle_init = 1'b1;
        step_nxt       = '0;
        state_nxt      = S_CORDIC;
      end
      S_CORDIC: begin
        ctl.cordic_step = 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_ROUND;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_ROUND: begin
        ctl.round = 1'b1;
        endpt_nxt = 1'b0;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        ctl.diff  = 1'b1;
        term_nxt  = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        ctl.acc = 1'b1;
        if (term_r == 2'd3) begin
          state_nxt = S_WRITE;
        end else begin
          term_nxt  = term_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_WRITE: begin
        ctl.write = 1'b1;
        if (endpt_r) begin
          state_nxt = S_EMIT;
        end else begin
          endpt_nxt = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORDIC) |-> (step_r < STEP_W'(CORDIC_STEPS)))
    else $error("cordic step counter out of range");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted request not decoded");

  a_second_endpoint: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && endpt_r) |=> (state_r == S_EMIT))
    else $error("rotation did not finish after second endpoint");

endmodule

// ----- rtl/lsrt_dp.sv -----
module lsrt_dp #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lsrt_pkg::in_item_t  in_item,
  input  lsrt_pkg::ctl_cmd_t  ctl,
  output lsrt_pkg::ctl_sts_t  sts,
  output lsrt_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_ready
);
  import lsrt_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int EW = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int DW = EW + 1;
  localparam int PW = DW + CS_W;
  localparam int AW = PW + 1;
  localparam int RW = AW - FRAC_SHIFT;
  localparam int SW = RW + 1;

  localparam logic signed [63:0] C_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] C_LO = -C_HI - 64'sd1;
  localparam logic signed [AW-1:0] ACC_RND =
    {{(AW - FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT - 1){1'b0}}};

  function automatic logic signed [CW-1:0] clamp(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > C_HI) r = C_HI;
    if (v < C_LO) r = C_LO;
    return r[CW-1:0];
  endfunction

  function automatic logic over(input logic signed [63:0] v);
    return (v > C_HI) || (v < C_LO);
  endfunction

  function automatic logic signed [FIELD_W-1:0] to_field(input logic signed [CW-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[FIELD_W-1:0];
  endfunction

  in_item_t                item_r;
  logic signed [CW-1:0]    coord_r [4];
  logic                    flag_r;
  logic signed [X_W-1:0]   x_r, y_r;
  logic signed [Z_W-1:0]   z_r;
  logic                    neg_r;
  logic signed [CS_W-1:0]  c_r, s_r;
  logic signed [DW-1:0]    dx_r, dy_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [AW-1:0]    accx_r, accy_r;
  out_item_t               out_r;
  logic                    out_valid_r;

  logic signed [FIELD_W-1:0] load_v  [4];
  logic signed [FIELD_W-1:0] shift_v [4];
  logic signed [CW-1:0]      ld_c    [4];
  logic signed [CW-1:0]      tr_c    [4];
  logic [3:0]                ld_o, tr_o;
  logic signed [EW:0]        tr_w;

  always_comb begin
    load_v[0]  = item_r.start_x;
    load_v[1]  = item_r.start_y;
    load_v[2]  = item_r.end_x;
    load_v[3]  = item_r.end_y;
    shift_v[0] = item_r.shift_x;
    shift_v[1] = item_r.shift_y;
    shift_v[2] = item_r.shift_x;
    shift_v[3] = item_r.shift_y;
    tr_w       = '0;
    for (int k = 0; k < 4; k++) begin
      ld_c[k] = clamp(64'(load_v[k]));
      ld_o[k] = over(64'(load_v[k]));
      tr_w    = (EW + 1)'(coord_r[k]) + (EW + 1)'(shift_v[k]);
      tr_c[k] = clamp(64'(tr_w));
      tr_o[k] = over(64'(tr_w));
    end
  end

  logic signed [A_W-1:0] a0, a1, a2, a3;
  logic                  fold_neg;
  logic signed [Z_W-1:0] z0;

  always_comb begin
    a0 = A_W'(item_r.angle);
    if (a0 >= DEG360) begin
      a1 = a0 - DEG360;
    end else if (a0 <= -DEG360) begin
      a1 = a0 + DEG360;
    end else begin
      a1 = a0;
    end
    if (a1 > DEG180) begin
      a2 = a1 - DEG360;
    end else if (a1 <= -DEG180) begin
      a2 = a1 + DEG360;
    end else begin
      a2 = a1;
    end
    fold_neg = 1'b0;
    if (a2 > DEG90) begin
      a3       = a2 - DEG180;
      fold_neg = 1'b1;
    end else if (a2 < -DEG90) begin
      a3       = a2 + DEG180;
      fold_neg = 1'b1;
    end else begin
      a3 = a2;
    end
    z0 = Z_W'(a3);
    z0 = z0 <<< ANG_SHIFT;
  end

  logic signed [X_W-1:0] xs, ys, x_n, y_n, xr, c_full, s_full;
  logic signed [Z_W-1:0] at, z_n;

  always_comb begin
    xs = x_r >>> ctl.step;
    ys = y_r >>> ctl.step;
    at = $signed(Z_W'(atan_q22(ctl.step)));
    if (z_r >= 0) begin
      x_n = x_r - ys;
      y_n = y_r + xs;
      z_n = z_r - at;
    end else begin
      x_n = x_r + ys;
      y_n = y_r - xs;
      z_n = z_r + at;
    end
    xr     = neg_r ? -x_r : x_r;
    c_full = (xr + X_W'(2)) >>> 2;
    xr     = neg_r ? -y_r : y_r;
    s_full = (xr + X_W'(2)) >>> 2;
  end

  logic signed [CW-1:0]   sel_x, sel_y;
  logic signed [DW-1:0]   op_a;
  logic signed [CS_W-1:0] op_b;
  logic signed [PW-1:0]   prod_w;
  logic signed [RW-1:0]   rx, ry;
  logic signed [SW-1:0]   sum_x, sum_y;
  logic signed [CW-1:0]   wr_x, wr_y;
  logic                   wr_ox, wr_oy;

  always_comb begin
    sel_x  = ctl.endpt ? coord_r[2] : coord_r[0];
    sel_y  = ctl.endpt ? coord_r[3] : coord_r[1];
    op_a   = (ctl.term == 2'd0 || ctl.term == 2'd2) ? dx_r : dy_r;
    op_b   = (ctl.term == 2'd0 || ctl.term == 2'd3) ? c_r : s_r;
    prod_w = op_a * op_b;
    rx     = $signed(accx_r[AW-1:FRAC_SHIFT]);
    ry     = $signed(accy_r[AW-1:FRAC_SHIFT]);
    sum_x  = SW'(rx) + SW'(item_r.center_x);
    sum_y  = SW'(ry) + SW'(item_r.center_y);
    wr_x   = clamp(64'(sum_x));
    wr_y   = clamp(64'(sum_y));
    wr_ox  = over(64'(sum_x));
    wr_oy  = over(64'(sum_y));
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_r <= in_item;
    end
    if (ctl.angle_init) begin
      x_r   <= INV_GAIN_Q30;
      y_r   <= '0;
      z_r   <= z0;
      neg_r <= fold_neg;
    end
    if (ctl.cordic_step) begin
      x_r <= x_n;
      y_r <= y_n;
      z_r <= z_n;
    end
    if (ctl.round) begin
      c_r <= c_full[CS_W-1:0];
      s_r <= s_full[CS_W-1:0];
    end
    if (ctl.diff) begin
      dx_r   <= DW'(sel_x) - DW'(item_r.center_x);
      dy_r   <= DW'(sel_y) - DW'(item_r.center_y);
      accx_r <= ACC_RND;
      accy_r <= ACC_RND;
    end
    if (ctl.mul) begin
      prod_r <= prod_w;
    end
    if (ctl.acc) begin
      case (ctl.term)
        2'd0:    accx_r <= accx_r + AW'(prod_r);
        2'd1:    accx_r <= accx_r - AW'(prod_r);
        default: accy_r <= accy_r + AW'(prod_r);
      endcase
    end
    if (ctl.emit) begin
      out_r.start_x   <= to_field(coord_r[0]);
      out_r.start_y   <= to_field(coord_r[1]);
      out_r.end_x     <= to_field(coord_r[2]);
      out_r.end_y     <= to_field(coord_r[3]);
      out_r.saturated <= flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r     <= '{default: '0};
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.capture) begin
        flag_r <= 1'b0;
      end
      if (ctl.apply) begin
        case (item_r.cmd)
          CMD_LOAD: begin
            for (int k = 0; k < 4; k++) coord_r[k] <= ld_c[k];
            flag_r <= |ld_o;
          end
          CMD_SHIFT: begin
            for (int k = 0; k < 4; k++) coord_r[k] <= tr_c[k];
            flag_r <= |tr_o;
          end
          default: ;
        endcase
      end
      if (ctl.write) begin
        if (ctl.endpt) begin
          coord_r[2] <= wr_x;
          coord_r[3] <= wr_y;
        end else begin
          coord_r[0] <= wr_x;
          coord_r[1] <= wr_y;
        end
        flag_r <= flag_r | wr_ox | wr_oy;
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.is_rotate = (item_r.cmd == CMD_ROTATE);
  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_item      = out_r;
  assign out_valid     = out_valid_r;

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> out_valid)
    else $error("emitted result not presented");

endmodule
